/* rtl/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the command frame parser: header codes,
// range limits, reset values, parse phases and the per-byte result.
// ----------------------------------------------------------------------------
package cfp_pkg;

    // frame header codes
    localparam logic [7:0] HDR_COUNT  = 8'hC3;
    localparam logic [7:0] HDR_STREAM = 8'hC4;
    localparam logic [7:0] HDR_TUNE   = 8'hC5;
    localparam logic [7:0] HDR_REF    = 8'hC6;
    localparam logic [7:0] HDR_CRESET = 8'hC7;
    localparam logic [7:0] CHK_INVERT = 8'hFF;

    // range limits of the payload values
    localparam logic [7:0]  COUNT_MIN    = 8'd1;
    localparam logic [7:0]  COUNT_MAX    = 8'd4;
    localparam logic [7:0]  FLAG_MAX     = 8'd1;
    localparam logic [7:0]  CRESET_REQ   = 8'd1;
    localparam logic [15:0] BATCH_MIN    = 16'd16;
    localparam logic [15:0] BATCH_MAX    = 16'd1024;
    localparam logic [15:0] LEVEL_MIN    = 16'd1;
    localparam logic [7:0]  FLUSH_MS_MIN = 8'd1;
    localparam logic [7:0]  FLUSH_MS_MAX = 8'd20;

    // settings after reset
    localparam logic [2:0]  COUNT_RESET    = 3'd1;
    localparam logic        STREAM_RESET   = 1'b1;
    localparam logic [10:0] BATCH_RESET    = 11'd240;
    localparam logic [10:0] LEVEL_RESET    = 11'd48;
    localparam logic [4:0]  FLUSH_MS_RESET = 5'd1;

    localparam int unsigned TUNE_BYTES = 5;

    // parse phase, one-hot
    typedef enum logic [14:0] {
        PH_IDLE     = 15'b000_0000_0000_0001,
        PH_CNT_PAY  = 15'b000_0000_0000_0010,
        PH_CNT_CHK  = 15'b000_0000_0000_0100,
        PH_STR_PAY  = 15'b000_0000_0000_1000,
        PH_STR_CHK  = 15'b000_0000_0001_0000,
        PH_REF_PAY  = 15'b000_0000_0010_0000,
        PH_REF_CHK  = 15'b000_0000_0100_0000,
        PH_CRS_PAY  = 15'b000_0000_1000_0000,
        PH_CRS_CHK  = 15'b000_0001_0000_0000,
        PH_TUNE_P0  = 15'b000_0010_0000_0000,
        PH_TUNE_P1  = 15'b000_0100_0000_0000,
        PH_TUNE_P2  = 15'b000_1000_0000_0000,
        PH_TUNE_P3  = 15'b001_0000_0000_0000,
        PH_TUNE_P4  = 15'b010_0000_0000_0000,
        PH_TUNE_CHK = 15'b100_0000_0000_0000
    } phase_t;

    // per-byte frame outcome
    typedef enum logic [1:0] {
        FS_NONE    = 2'd0,
        FS_APPLIED = 2'd1,
        FS_DROPPED = 2'd2
    } frame_status_t;

    // one received item
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_last;
    } in_item_t;

    // result of one byte: settings after it plus event pulses
    typedef struct packed {
        logic [2:0]    encoder_count;
        logic          stream_on;
        logic [10:0]   batch_size;
        logic [10:0]   flush_level;
        logic [4:0]    flush_ms;
        logic          reference_write;
        logic          reference_value;
        logic          counter_reset_pulse;
        frame_status_t frame_status;
    } parse_res_t;

endpackage

/* rtl/checksummed_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// checksummed_command_frame_parser
// Parses checksummed command frames from a byte stream, holds the settings
// they carry and pulses the reference-write and counter-reset events.
//
//   channel   direction   handshake            payload
//   in        to block    in_valid/in_ready    rx_byte, packet_last
//   out       from block  out_valid/out_ready  settings, pulses, frame_status,
//                                              packet_last_out
//
// One result per byte, one byte per cycle sustained while out_ready holds; each
// result passes the input register, then the result register.
// The frame state machine handles each byte in the step that takes it.
// Reset puts the parser in idle with the default settings; no result pending.
// A stall on out holds the result register and fills the input register,
// after which in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module checksummed_command_frame_parser
    import cfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        packet_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  encoder_count,
    output logic        stream_on,
    output logic [10:0] batch_size,
    output logic [10:0] flush_level,
    output logic [4:0]  flush_ms,
    output logic        reference_write,
    output logic        reference_value,
    output logic        counter_reset_pulse,
    output logic [1:0]  frame_status,
    output logic        packet_last_out
);

    in_item_t   in_item;
    in_item_t   item;
    logic       item_valid;
    logic       step;
    parse_res_t res;

    logic       out_valid_reg;
    logic       out_valid_next;
    parse_res_t res_reg;
    logic       last_reg;

    assign in_item.rx_byte     = rx_byte;
    assign in_item.packet_last = packet_last;

    // a byte moves on when the result register is free or being emptied
    assign step = item_valid && (!out_valid_reg || out_ready);

    // input register
    cfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (step)
    );

    // frame state machine and settings
    cfp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (item.rx_byte),
        .res     (res)
    );

    // result valid flag
    assign out_valid_next = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg  <= res;
            last_reg <= item.packet_last;
        end
    end

    assign out_valid           = out_valid_reg;
    assign encoder_count       = res_reg.encoder_count;
    assign stream_on           = res_reg.stream_on;
    assign batch_size          = res_reg.batch_size;
    assign flush_level         = res_reg.flush_level;
    assign flush_ms            = res_reg.flush_ms;
    assign reference_write     = res_reg.reference_write;
    assign reference_value     = res_reg.reference_value;
    assign counter_reset_pulse = res_reg.counter_reset_pulse;
    assign frame_status        = res_reg.frame_status;
    assign packet_last_out     = last_reg;

    // event pulses only come with an applied frame
    a_pulse_applied: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reference_write || counter_reset_pulse)
        |-> frame_status == FS_APPLIED)
        else $error("event pulse without applied frame");

    // one frame gives at most one event
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(reference_write && counter_reset_pulse))
        else $error("two events on one item");

    // reference value is zero without its pulse
    a_ref_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reference_value |-> reference_write)
        else $error("reference value without pulse");

endmodule

/* rtl/cfp_in_stage.sv */
// ----------------------------------------------------------------------------
// cfp_in_stage
// Input register: holds one received item until the parse step takes it,
// and takes a new item in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
module cfp_in_stage
    import cfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     item_valid,
    output in_item_t item,
    input  logic     take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // free when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/cfp_parse.sv */
// ----------------------------------------------------------------------------
// cfp_parse
// Frame state machine and settings registers. One byte per step: decodes
// headers, checks payload ranges and checksums, applies settings and
// produces the result of the byte.
// ----------------------------------------------------------------------------
module cfp_parse
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output parse_res_t res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  pending_reg;
    logic [2:0]  pending_next;
    logic [7:0]  store_reg [TUNE_BYTES];
    logic [TUNE_BYTES-1:0] store_we;

    logic [2:0]  encoder_count_reg;
    logic [2:0]  encoder_count_next;
    logic        stream_on_reg;
    logic        stream_on_next;
    logic [10:0] batch_size_reg;
    logic [10:0] batch_size_next;
    logic [10:0] flush_level_reg;
    logic [10:0] flush_level_next;
    logic [4:0]  flush_ms_reg;
    logic [4:0]  flush_ms_next;

    logic          ref_wr;
    logic          ref_val;
    logic          crs;
    frame_status_t status;

    logic [7:0]  pend_byte;
    logic [7:0]  tune_sum;
    logic [15:0] tune_bs;
    logic [15:0] tune_th;
    logic [7:0]  tune_ms;
    logic        tune_ok;

    // single-byte frame checksum operand
    assign pend_byte = {5'd0, pending_reg};

    // tune frame fields and checks
    assign tune_sum = HDR_TUNE ^ store_reg[0] ^ store_reg[1] ^ store_reg[2]
                      ^ store_reg[3] ^ store_reg[4] ^ CHK_INVERT;
    assign tune_bs  = {store_reg[1], store_reg[0]};
    assign tune_th  = {store_reg[3], store_reg[2]};
    assign tune_ms  = store_reg[4];
    assign tune_ok  = (tune_bs >= BATCH_MIN) && (tune_bs <= BATCH_MAX)
                      && (tune_th >= LEVEL_MIN) && (tune_th <= tune_bs)
                      && (tune_ms >= FLUSH_MS_MIN) && (tune_ms <= FLUSH_MS_MAX);

    // next phase, settings and outcome of the current byte
    always_comb
    begin
        phase_next         = PH_IDLE;
        pending_next       = pending_reg;
        store_we           = '0;
        encoder_count_next = encoder_count_reg;
        stream_on_next     = stream_on_reg;
        batch_size_next    = batch_size_reg;
        flush_level_next   = flush_level_reg;
        flush_ms_next      = flush_ms_reg;
        ref_wr             = 1'b0;
        ref_val            = 1'b0;
        crs                = 1'b0;
        status             = FS_NONE;
        unique case (phase_reg)
            PH_TUNE_P0:
            begin
                store_we[0] = 1'b1;
                phase_next  = PH_TUNE_P1;
            end
            PH_TUNE_P1:
            begin
                store_we[1] = 1'b1;
                phase_next  = PH_TUNE_P2;
            end
            PH_TUNE_P2:
            begin
                store_we[2] = 1'b1;
                phase_next  = PH_TUNE_P3;
            end
            PH_TUNE_P3:
            begin
                store_we[3] = 1'b1;
                phase_next  = PH_TUNE_P4;
            end
            PH_TUNE_P4:
            begin
                store_we[4] = 1'b1;
                phase_next  = PH_TUNE_CHK;
            end
            PH_TUNE_CHK:
            begin
                status = FS_DROPPED;
                if ((rx_byte == tune_sum) && tune_ok)
                begin
                    batch_size_next  = tune_bs[10:0];
                    flush_level_next = tune_th[10:0];
                    flush_ms_next    = tune_ms[4:0];
                    status           = FS_APPLIED;
                end
            end
            PH_CNT_PAY:
            begin
                if ((rx_byte >= COUNT_MIN) && (rx_byte <= COUNT_MAX))
                begin
                    pending_next = rx_byte[2:0];
                    phase_next   = PH_CNT_CHK;
                end
                else
                begin
                    status = FS_DROPPED;
                end
            end
            PH_STR_PAY:
            begin
                if (rx_byte <= FLAG_MAX)
                begin
                    pending_next = rx_byte[2:0];
                    phase_next   = PH_STR_CHK;
                end
                else
                begin
                    status = FS_DROPPED;
                end
            end
            PH_REF_PAY:
            begin
                if (rx_byte <= FLAG_MAX)
                begin
                    pending_next = rx_byte[2:0];
                    phase_next   = PH_REF_CHK;
                end
                else
                begin
                    status = FS_DROPPED;
                end
            end
            PH_CRS_PAY:
            begin
                if (rx_byte == CRESET_REQ)
                begin
                    pending_next = rx_byte[2:0];
                    phase_next   = PH_CRS_CHK;
                end
                else
                begin
                    status = FS_DROPPED;
                end
            end
            PH_CNT_CHK:
            begin
                status = FS_DROPPED;
                if (rx_byte == (HDR_COUNT ^ pend_byte ^ CHK_INVERT))
                begin
                    encoder_count_next = pending_reg;
                    status             = FS_APPLIED;
                end
            end
            PH_STR_CHK:
            begin
                status = FS_DROPPED;
                if (rx_byte == (HDR_STREAM ^ pend_byte ^ CHK_INVERT))
                begin
                    stream_on_next = pending_reg[0];
                    status         = FS_APPLIED;
                end
            end
            PH_REF_CHK:
            begin
                status = FS_DROPPED;
                if (rx_byte == (HDR_REF ^ pend_byte ^ CHK_INVERT))
                begin
                    ref_wr  = 1'b1;
                    ref_val = pending_reg[0];
                    status  = FS_APPLIED;
                end
            end
            PH_CRS_CHK:
            begin
                status = FS_DROPPED;
                if (rx_byte == (HDR_CRESET ^ pend_byte ^ CHK_INVERT))
                begin
                    crs    = 1'b1;
                    status = FS_APPLIED;
                end
            end
            default:
            begin
                // idle: look for a header, skip anything else
                case (rx_byte)
                    HDR_COUNT:  phase_next = PH_CNT_PAY;
                    HDR_STREAM: phase_next = PH_STR_PAY;
                    HDR_TUNE:   phase_next = PH_TUNE_P0;
                    HDR_REF:    phase_next = PH_REF_PAY;
                    HDR_CRESET: phase_next = PH_CRS_PAY;
                    default:    phase_next = PH_IDLE;
                endcase
            end
        endcase
    end

    // control state and settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            pending_reg       <= 3'd0;
            encoder_count_reg <= COUNT_RESET;
            stream_on_reg     <= STREAM_RESET;
            batch_size_reg    <= BATCH_RESET;
            flush_level_reg   <= LEVEL_RESET;
            flush_ms_reg      <= FLUSH_MS_RESET;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            pending_reg       <= pending_next;
            encoder_count_reg <= encoder_count_next;
            stream_on_reg     <= stream_on_next;
            batch_size_reg    <= batch_size_next;
            flush_level_reg   <= flush_level_next;
            flush_ms_reg      <= flush_ms_next;
        end
    end

    // tune payload bytes, one fixed slot per phase
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TUNE_BYTES; i++)
        begin
            if (step && store_we[i])
            begin
                store_reg[i] <= rx_byte;
            end
        end
    end

    // result of this byte
    always_comb
    begin
        res.encoder_count       = encoder_count_next;
        res.stream_on           = stream_on_next;
        res.batch_size          = batch_size_next;
        res.flush_level         = flush_level_next;
        res.flush_ms            = flush_ms_next;
        res.reference_write     = ref_wr;
        res.reference_value     = ref_val;
        res.counter_reset_pulse = crs;
        res.frame_status        = status;
    end

    // threshold never exceeds batch size
    a_level_le_batch: assert property (@(posedge clk) disable iff (!rst_n)
        flush_level_reg <= batch_size_reg)
        else $error("flush level above batch size");

    // batch size stays in range
    a_batch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (batch_size_reg >= BATCH_MIN[10:0]) && (batch_size_reg <= BATCH_MAX[10:0]))
        else $error("batch size out of range");

    // checksum byte always ends the frame
    a_chk_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_reg == PH_TUNE_CHK || phase_reg == PH_CNT_CHK
                 || phase_reg == PH_STR_CHK || phase_reg == PH_REF_CHK
                 || phase_reg == PH_CRS_CHK)
        |=> phase_reg == PH_IDLE)
        else $error("frame not closed after checksum byte");

endmodule
